/* hw/rtl/csm_pkg.sv */
// Shared types, widths and constants for the sensor min/max calibrator.
// Used by csm_mark_store, csm_thresh_div and sensor_minmax_calibrator.
`timescale 1ns / 1ps

package csm_pkg;

  localparam int SAMPLE_BITS      = 12;
  localparam int CH_W             = 4;
  localparam int NUM_W            = 4;
  localparam int FRAC_BITS        = 4;
  localparam int LO_W             = SAMPLE_BITS + 1;
  localparam int THR_W            = 16;
  localparam int PROD_W           = SAMPLE_BITS + NUM_W;
  localparam int QUO_W            = PROD_W + FRAC_BITS;
  localparam int DIV_CNT_W        = $clog2(QUO_W + 1);
  localparam int IN_DATA_W        = 16;
  localparam int OUT_DATA_W       = 64;
  localparam int CFG_ADDR_W       = 2;
  localparam int NUM_CHANNELS_DEF = 15;

  localparam logic [LO_W-1:0]        SAMPLE_BOUND = LO_W'(5000);
  localparam logic [LO_W-1:0]        MIN_EMPTY    = LO_W'(4096);
  localparam logic [SAMPLE_BITS-1:0] MAX_EMPTY    = '0;
  localparam logic [THR_W-1:0]       THR_MAX      = '1;

  localparam logic [NUM_W-1:0] UPPER_NUM_RST = NUM_W'(3);
  localparam logic [NUM_W-1:0] LOWER_NUM_RST = NUM_W'(2);
  localparam logic [NUM_W-1:0] DEN_RST       = NUM_W'(5);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_UPPER_NUM = 2'd0,
    CFG_LOWER_NUM = 2'd1,
    CFG_FRAC_DEN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctrl_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] den;
  } div_req_t;

endpackage

/* hw/rtl/csm_mark_store.sv */
// Per-channel low/high mark memory with a registered read.
// Valid bits give the reset marks for entries never written. Depends on csm_pkg.
`timescale 1ns / 1ps

module csm_mark_store #(
  parameter int NUM_CHANNELS = csm_pkg::NUM_CHANNELS_DEF,
  parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  csm_pkg::store_ctrl_t             ctrl,
  input  logic [IDX_W-1:0]                 addr,
  input  logic [csm_pkg::LO_W-1:0]         wr_min,
  input  logic [csm_pkg::SAMPLE_BITS-1:0]  wr_max,
  output logic [csm_pkg::LO_W-1:0]         rd_min,
  output logic [csm_pkg::SAMPLE_BITS-1:0]  rd_max
);
  import csm_pkg::*;

  localparam int WORD_W = LO_W + SAMPLE_BITS;

  logic [WORD_W-1:0]       mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] valid_r;
  logic [WORD_W-1:0]       rd_word_r;
  logic                    rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[addr] <= {wr_min, wr_max};
    end
    if (ctrl.rd_en) begin
      rd_word_r  <= mem[addr];
      rd_valid_r <= valid_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctrl.wr_en) begin
      valid_r[addr] <= 1'b1;
    end
  end

  assign rd_min = rd_valid_r ? rd_word_r[WORD_W-1:SAMPLE_BITS] : MIN_EMPTY;
  assign rd_max = rd_valid_r ? rd_word_r[SAMPLE_BITS-1:0] : MAX_EMPTY;

endmodule

/* hw/rtl/csm_thresh_div.sv */
// Bit-serial restoring divider for one threshold: base + (product << 4) / den,
// one quotient bit per cycle, saturated to 16 bits. Depends on csm_pkg.
`timescale 1ns / 1ps

module csm_thresh_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  csm_pkg::div_req_t           req,
  input  logic [csm_pkg::PROD_W-1:0]  product,
  input  logic [csm_pkg::THR_W-1:0]   base,
  output logic                        done,
  output logic [csm_pkg::THR_W-1:0]   result
);
  import csm_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [QUO_W-1:0]     quo_r;
  logic [NUM_W-1:0]     rem_r;
  logic [NUM_W-1:0]     den_r;
  logic [THR_W-1:0]     base_r;

  logic [NUM_W:0]       trial;
  logic                 ge;
  logic [NUM_W:0]       diff;
  logic [QUO_W:0]       sum;

  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r  <= {product, FRAC_BITS'(0)};
      rem_r  <= '0;
      den_r  <= (req.den == '0) ? NUM_W'(1) : req.den;
      base_r <= base;
    end else if (busy_r) begin
      quo_r <= {quo_r[QUO_W-2:0], ge};
      rem_r <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
    end
  end

  assign sum    = (QUO_W + 1)'(base_r) + (QUO_W + 1)'(quo_r);
  assign result = (sum > (QUO_W + 1)'(THR_MAX)) ? THR_MAX : sum[THR_W-1:0];
  assign done   = done_r;

endmodule

/* hw/rtl/sensor_minmax_calibrator.sv */
// Per-channel min/max light-sensor calibrator: one result beat per sample beat.
// Instantiates csm_mark_store and two csm_thresh_div lanes. Depends on csm_pkg.
`timescale 1ns / 1ps

// One sample at a time. The mark memory is read at the accepting edge. The READ
// state updates the marks from the read data and writes them back, the MUL state
// forms the span products and starts both divider lanes, the DIV state runs the
// bit-serial threshold divide until both lanes raise their done flags, and the
// OUT state loads the output register. Both thresholds divide in parallel. A new
// sample is accepted in the idle state after the previous result sits in the
// output register, even if that result has not yet been taken; a result still
// waiting when the next one is ready holds the next one and the input with it.
// A channel at or above NUM_CHANNELS leaves the marks alone and reports empty
// marks. Reset clears the marks at once through per-entry valid bits; no
// clearing pass.

module sensor_minmax_calibrator #(
  parameter int NUM_CHANNELS = csm_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // [3:0] channel, [15:4] sample
  input  logic [csm_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] channel_out, [16:4] low_mark, [28:17] high_mark, [44:29] upper_threshold,
  // [60:45] lower_threshold, [61] calibrated, [63:62] zero
  output logic [csm_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [csm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [csm_pkg::NUM_W-1:0]       cfg_wdata
);
  import csm_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  state_t state_r, state_nxt;

  logic [NUM_W-1:0]       up_num_r, dn_num_r, den_r;
  logic [CH_W-1:0]        ch_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [LO_W-1:0]        lo_r;
  logic [SAMPLE_BITS-1:0] hi_r;
  logic                   cal_r;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  store_ctrl_t            st_ctrl;
  logic [IDX_W-1:0]       st_addr;
  logic [LO_W-1:0]        rd_min, new_min;
  logic [SAMPLE_BITS-1:0] rd_max, new_max;
  logic                   in_range;
  logic                   in_fire;
  logic                   out_load;

  div_req_t               up_req, dn_req;
  logic [SAMPLE_BITS-1:0] span;
  logic [PROD_W-1:0]      up_prod, dn_prod;
  logic [THR_W-1:0]       base;
  logic                   up_done, dn_done;
  logic [THR_W-1:0]       up_res, dn_res;

  assign in_fire  = in_tvalid && in_tready;
  assign in_range = int'(ch_r) < NUM_CHANNELS;
  assign st_addr  = in_fire ? IDX_W'(in_tdata[CH_W-1:0]) : IDX_W'(ch_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_num_r <= UPPER_NUM_RST;
      dn_num_r <= LOWER_NUM_RST;
      den_r    <= DEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_UPPER_NUM: up_num_r <= cfg_wdata;
        CFG_LOWER_NUM: dn_num_r <= cfg_wdata;
        CFG_FRAC_DEN:  den_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    st_ctrl.rd_en = 1'b0;
    st_ctrl.wr_en = 1'b0;
    up_req.start  = 1'b0;
    up_req.den    = den_r;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready     = 1'b1;
        st_ctrl.rd_en = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        st_ctrl.wr_en = in_range;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        up_req.start = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        if (up_done && dn_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ch_r     <= in_tdata[CH_W-1:0];
      sample_r <= in_tdata[CH_W +: SAMPLE_BITS];
    end
  end

  // Update marks from the read data
  always_comb begin
    new_max = rd_max;
    new_min = rd_min;
    if (sample_r > rd_max && LO_W'(sample_r) < SAMPLE_BOUND) begin
      new_max = sample_r;
    end
    if (LO_W'(sample_r) < rd_min && sample_r != '0) begin
      new_min = LO_W'(sample_r);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      lo_r  <= in_range ? new_min : MIN_EMPTY;
      hi_r  <= in_range ? new_max : MAX_EMPTY;
      cal_r <= in_range && (LO_W'(new_max) >= new_min);
    end
  end

  csm_mark_store #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .IDX_W        (IDX_W)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (st_ctrl),
    .addr   (st_addr),
    .wr_min (new_min),
    .wr_max (new_max),
    .rd_min (rd_min),
    .rd_max (rd_max)
  );

  // Span products feed the divider lanes
  assign span         = hi_r - lo_r[SAMPLE_BITS-1:0];
  assign up_prod      = PROD_W'(span) * PROD_W'(up_num_r);
  assign dn_prod      = PROD_W'(span) * PROD_W'(dn_num_r);
  assign base         = {lo_r[SAMPLE_BITS-1:0], FRAC_BITS'(0)};
  assign dn_req.start = up_req.start;
  assign dn_req.den   = den_r;

  csm_thresh_div u_div_up (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (up_req),
    .product (up_prod),
    .base    (base),
    .done    (up_done),
    .result  (up_res)
  );

  csm_thresh_div u_div_dn (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (dn_req),
    .product (dn_prod),
    .base    (base),
    .done    (dn_done),
    .result  (dn_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {2'b00, cal_r,
                     cal_r ? dn_res : THR_W'(0),
                     cal_r ? up_res : THR_W'(0),
                     hi_r, lo_r, ch_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_READ)
    else $error("accepted beat did not start a mark read");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_ctrl.wr_en |-> state_r == ST_READ && in_range)
    else $error("mark write outside update cycle or channel range");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> up_done == dn_done)
    else $error("threshold divider lanes out of step");

  a_cal_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[61] == (out_tdata[28:17] >= out_tdata[16:4]))
    else $error("calibrated flag disagrees with marks");

  a_uncal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[61] |-> out_tdata[60:29] == '0)
    else $error("thresholds nonzero while not calibrated");

endmodule

/* dv/sensor_minmax_calibrator_test.sv */
// Self-checking bench for sensor_minmax_calibrator: tracks per-channel marks and
// thresholds in a local predictor and scores every result beat against it in order.
// Depends on csm_pkg and the sensor_minmax_calibrator RTL.
`timescale 1ns / 1ps

module sensor_minmax_calibrator_test;
  import csm_pkg::*;

  localparam int NUM_CH      = 15;
  localparam int PHASE_BEATS = 220;
  localparam int RUN_BEATS   = 8 * PHASE_BEATS;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [CH_W-1:0]        channel;
  } sample_beat_t;

  typedef struct packed {
    logic                   calibrated;
    logic [THR_W-1:0]       lower_thr;
    logic [THR_W-1:0]       upper_thr;
    logic [SAMPLE_BITS-1:0] high_mark;
    logic [LO_W-1:0]        low_mark;
    logic [CH_W-1:0]        channel;
  } cal_result_t;

  typedef struct {
    logic [NUM_W-1:0] up_num;
    logic [NUM_W-1:0] lo_num;
    logic [NUM_W-1:0] den;
  } fraction_set_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [NUM_W-1:0]       cfg_wdata = '0;

  sample_beat_t pending_samples[$];
  cal_result_t  expected_results[$];

  logic [LO_W-1:0]        min_mark[NUM_CH];
  logic [SAMPLE_BITS-1:0] max_mark[NUM_CH];
  logic [NUM_W-1:0]       upper_num_q, lower_num_q, frac_den_q;

  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  int send_gap = 0;
  int recv_gap = 0;
  int errors = 0;
  int cycles = 0;
  int random_count = 0;

  sensor_minmax_calibrator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [THR_W-1:0] threshold_q4(logic [LO_W-1:0] lo,
                                                    logic [LO_W-1:0] span,
                                                    logic [NUM_W-1:0] num);
    int unsigned d;
    int unsigned t;
    d = (frac_den_q == 0) ? 1 : 32'(frac_den_q);
    t = (32'(lo) << FRAC_BITS) + ((32'(span) * 32'(num)) << FRAC_BITS) / d;
    return (t > 32'(THR_MAX)) ? THR_MAX : t[THR_W-1:0];
  endfunction

  function automatic cal_result_t predict_calibration(sample_beat_t b);
    cal_result_t r;
    logic [LO_W-1:0] lo;
    logic [LO_W-1:0] hi;
    r = '0;
    r.channel = b.channel;
    r.low_mark = MIN_EMPTY;
    r.high_mark = MAX_EMPTY;
    if (int'(b.channel) < NUM_CH) begin
      if (b.sample > max_mark[b.channel] && LO_W'(b.sample) < SAMPLE_BOUND)
        max_mark[b.channel] = b.sample;
      if (LO_W'(b.sample) < min_mark[b.channel] && b.sample != 0)
        min_mark[b.channel] = LO_W'(b.sample);
      lo = min_mark[b.channel];
      hi = LO_W'(max_mark[b.channel]);
      r.low_mark = lo;
      r.high_mark = max_mark[b.channel];
      if (hi >= lo) begin
        r.calibrated = 1'b1;
        r.upper_thr = threshold_q4(lo, hi - lo, upper_num_q);
        r.lower_thr = threshold_q4(lo, hi - lo, lower_num_q);
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // scoreboard: track register writes, predict on input beats, check output beats
  always @(posedge clk) begin
    cal_result_t want;
    cal_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        min_mark[i] = MIN_EMPTY;
        max_mark[i] = MAX_EMPTY;
      end
      upper_num_q = UPPER_NUM_RST;
      lower_num_q = LOWER_NUM_RST;
      frac_den_q = DEN_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_UPPER_NUM: upper_num_q = cfg_wdata;
          CFG_LOWER_NUM: lower_num_q = cfg_wdata;
          CFG_FRAC_DEN:  frac_den_q = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(cal_result_t)-1:0];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat: expected none actual %h", $time, out_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("channel_out", want.channel, got.channel);
          check_field("low_mark", want.low_mark, got.low_mark);
          check_field("high_mark", want.high_mark, got.high_mark);
          check_field("upper_threshold", want.upper_thr, got.upper_thr);
          check_field("lower_threshold", want.lower_thr, got.lower_thr);
          check_field("calibrated", want.calibrated, got.calibrated);
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_calibration(sample_beat_t'(in_tdata)));
    end
  end

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap != 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_samples.size() != 0) begin
        in_tdata <= pending_samples.pop_front();
        in_tvalid <= 1'b1;
        send_gap <= sender_idles ? $urandom_range(0, 6) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result sink, with random stalls while receiver_idles is set
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap <= 0;
    end else if (out_tready && out_tvalid) begin
      w = receiver_idles ? $urandom_range(0, 6) : 0;
      recv_gap <= w;
      out_tready <= (w == 0);
    end else if (!out_tready) begin
      if (recv_gap <= 1) begin
        out_tready <= 1'b1;
        recv_gap <= 0;
      end else begin
        recv_gap <= recv_gap - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_sample(int ch, int s);
    sample_beat_t b;
    b.channel = CH_W'(ch);
    b.sample = SAMPLE_BITS'(s);
    pending_samples.push_back(b);
  endtask

  // band around mid-scale widens over the run so marks keep moving
  task automatic push_random_sample();
    int ch;
    int s;
    int spread;
    int pick;
    ch = ($urandom_range(0, 29) == 0) ? 15 : $urandom_range(0, NUM_CH - 1);
    spread = 1 + (random_count * 2047) / RUN_BEATS;
    pick = $urandom_range(0, 9);
    if (pick < 6)
      s = $urandom_range(2048 - spread, 2047 + spread);
    else if (pick == 6)
      s = 0;
    else if (pick == 7)
      s = ($urandom_range(0, 1) != 0) ? 4095 : 1;
    else
      s = $urandom_range(0, 4095);
    random_count++;
    push_sample(ch, s);
  endtask

  task automatic write_fraction(cfg_idx_t idx, logic [NUM_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  initial begin
    fraction_set_t settings[8];
    settings[0] = '{UPPER_NUM_RST, LOWER_NUM_RST, DEN_RST};
    settings[1] = '{4'd7, 4'd6, 4'd9};
    settings[2] = '{4'd0, 4'd0, 4'd1};
    settings[3] = '{4'd15, 4'd15, 4'd1};
    settings[4] = '{4'd15, 4'd0, 4'd0};
    settings[5] = '{4'd1, 4'd14, 4'd15};
    settings[6] = '{NUM_W'($urandom), NUM_W'($urandom), NUM_W'($urandom_range(1, 15))};
    settings[7] = '{UPPER_NUM_RST, LOWER_NUM_RST, DEN_RST};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty channel, out-of-range channel, single sample, zero after marks, extremes
    push_sample(0, 0);
    push_sample(15, 4095);
    push_sample(15, 0);
    push_sample(1, 4095);
    push_sample(1, 1);
    push_sample(1, 0);
    push_sample(1, 2048);
    push_sample(2, 2048);
    push_sample(2, 2047);
    push_sample(14, 'hAAA);
    push_sample(14, 'h555);
    push_sample(0, 1);
    push_sample(0, 4095);
    push_sample(3, 1);
    push_sample(3, 0);

    for (int p = 0; p < 8; p++) begin
      if (p != 0) begin
        wait_drained();
        repeat (2) @(negedge clk);
        write_fraction(CFG_UPPER_NUM, settings[p].up_num);
        write_fraction(CFG_LOWER_NUM, settings[p].lo_num);
        write_fraction(CFG_FRAC_DEN, settings[p].den);
        @(negedge clk);
      end
      sender_idles = (p != 2 && p != 5);
      receiver_idles = (p != 2);
      for (int i = 0; i < PHASE_BEATS; i++)
        push_random_sample();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/csm_pkg.sv
hw/rtl/csm_mark_store.sv
hw/rtl/csm_thresh_div.sv
hw/rtl/sensor_minmax_calibrator.sv
dv/sensor_minmax_calibrator_test.sv
